### sv/lzwp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lzwp_pkg;

    // Default code width behaviour
    localparam int unsigned INITIAL_WIDTH_DEF = 9;
    localparam int unsigned INITIAL_BUMP_DEF  = 512;
    localparam int unsigned MAX_WIDTH_DEF     = 16;

    localparam int unsigned CODE_W   = 16;
    localparam int unsigned INDEX_W  = 17;
    localparam int unsigned WIDTH_W  = 5;
    localparam int unsigned CFG_DATA_W = 17;
    localparam int unsigned CFG_IDX_W  = 2;

    // Opcodes
    localparam logic OP_PACK   = 1'b0;
    localparam logic OP_FINISH = 1'b1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_INDEX   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RESET_WIDTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EOF_CODE    = 2'd2;

    // Register reset values
    localparam logic [INDEX_W-1:0] MAX_INDEX_RST = 17'd4096;
    localparam logic               RESET_WIDTH_RST = 1'b1;
    localparam logic [CODE_W-1:0]  EOF_CODE_RST  = 16'd256;

    typedef struct packed {
        logic                opcode;
        logic [CODE_W-1:0]   code_value;
        logic [INDEX_W-1:0]  dict_index;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
    } out_item_t;

    typedef struct packed {
        logic [INDEX_W-1:0] max_index;
        logic               reset_width_on_full;
        logic [CODE_W-1:0]  eof_code;
    } cfg_t;

    // Bytes produced by one item, low byte first
    typedef struct packed {
        logic [1:0]      count;
        logic [2:0][7:0] bytes;
    } pack_res_t;

endpackage

`default_nettype wire

### sv/lzw_code_bit_packer.sv
// With room in the byte queue, an accepted item is held in the item register and its
// bytes are then written into the byte queue, from whose head the first is offered.
// Throughput: one item per cycle while the byte queue has room; codes of nine
// bits or more yield up to two bytes, so the one-byte-per-cycle output port
// and the four-entry byte queue limit the sustained rate of codes.
// Reset: asynchronous, active low; clears the queue, the bit buffer and restores
// the initial code width, bump index and register defaults.
`timescale 1ns / 1ps
`default_nettype none

module lzw_code_bit_packer #(
    parameter int unsigned INITIAL_WIDTH = lzwp_pkg::INITIAL_WIDTH_DEF,
    parameter int unsigned INITIAL_BUMP  = lzwp_pkg::INITIAL_BUMP_DEF,
    parameter int unsigned MAX_WIDTH     = lzwp_pkg::MAX_WIDTH_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire lzwp_pkg::in_item_t                   in_item,
    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output lzwp_pkg::out_item_t                       out_item,
    input  wire logic                                 cfg_we,
    input  wire logic [lzwp_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [lzwp_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import lzwp_pkg::*;

    in_item_t  item_reg;
    logic      item_valid_reg;
    cfg_t      cfg_reg;
    logic      room;
    logic      fire;
    pack_res_t res;

    assign fire     = item_valid_reg && room;
    assign in_ready = !item_valid_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            item_valid_reg <= in_valid;
        end
    end

    // Hold the item until the packer takes it
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_index           <= MAX_INDEX_RST;
            cfg_reg.reset_width_on_full <= RESET_WIDTH_RST;
            cfg_reg.eof_code            <= EOF_CODE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MAX_INDEX:   cfg_reg.max_index <= cfg_data[INDEX_W-1:0];
                CFG_RESET_WIDTH: cfg_reg.reset_width_on_full <= cfg_data[0];
                CFG_EOF_CODE:    cfg_reg.eof_code <= cfg_data[CODE_W-1:0];
                default:         cfg_reg <= cfg_reg;
            endcase
        end
    end

    lzwp_pack_unit #(
        .INITIAL_WIDTH (INITIAL_WIDTH),
        .INITIAL_BUMP  (INITIAL_BUMP),
        .MAX_WIDTH     (MAX_WIDTH)
    ) u_pack (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .item  (item_reg),
        .cfg   (cfg_reg),
        .res   (res)
    );

    lzwp_out_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (fire),
        .res       (res),
        .room      (room),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

endmodule

`default_nettype wire

### sv/lzwp_pack_unit.sv
`timescale 1ns / 1ps
`default_nettype none

module lzwp_pack_unit #(
    parameter int unsigned INITIAL_WIDTH = lzwp_pkg::INITIAL_WIDTH_DEF,
    parameter int unsigned INITIAL_BUMP  = lzwp_pkg::INITIAL_BUMP_DEF,
    parameter int unsigned MAX_WIDTH     = lzwp_pkg::MAX_WIDTH_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                fire,
    input  wire lzwp_pkg::in_item_t  item,
    input  wire lzwp_pkg::cfg_t      cfg,
    output lzwp_pkg::pack_res_t      res
);
    import lzwp_pkg::*;

    logic [7:0]         pend_reg, pend_next;
    logic [2:0]         fill_reg, fill_next;
    logic [WIDTH_W-1:0] width_reg, width_next;
    logic [INDEX_W-1:0] bump_reg, bump_next;

    logic [CODE_W-1:0]  code_sel;
    logic [CODE_W-1:0]  masked;
    logic [23:0]        merged;
    logic [WIDTH_W-1:0] total;
    logic [1:0]         nfull;
    logic [2:0]         rem;
    logic [7:0]         leftover;
    logic               finish;
    logic [INDEX_W:0]   idx1;
    logic [INDEX_W:0]   lim1;
    logic               below;
    logic               equal;
    logic               grow;
    logic               restore;

    always_comb
    begin
        finish   = (item.opcode == OP_FINISH);
        code_sel = finish ? cfg.eof_code : item.code_value;
        // Mask to the current width; a shift of 16 or more leaves the full mask
        masked   = code_sel & ~(16'hFFFF << width_reg);
        merged   = {16'b0, pend_reg} | ({8'b0, masked} << fill_reg);
        total    = {2'b0, fill_reg} + width_reg;
        nfull    = total[4:3];
        rem      = total[2:0];

        case (nfull)
            2'd0:    leftover = merged[7:0];
            2'd1:    leftover = merged[15:8];
            default: leftover = merged[23:16];
        endcase

        res.bytes[0] = merged[7:0];
        res.bytes[1] = merged[15:8];
        res.bytes[2] = merged[23:16];
        res.count    = nfull + {1'b0, (finish && (rem != 3'd0))};

        if (finish)
        begin
            pend_next = 8'd0;
            fill_next = 3'd0;
        end
        else
        begin
            pend_next = leftover;
            fill_next = rem;
        end

        // index < max_index-1 and index == max_index-1, without a signed compare
        idx1    = {1'b0, item.dict_index} + (INDEX_W+1)'(1);
        lim1    = {1'b0, cfg.max_index};
        below   = (idx1 < lim1);
        equal   = (idx1 == lim1);
        grow    = below && (item.dict_index == bump_reg)
                  && (width_reg < WIDTH_W'(MAX_WIDTH));
        restore = !below && !equal && cfg.reset_width_on_full;

        width_next = width_reg;
        bump_next  = bump_reg;
        if (grow)
        begin
            width_next = width_reg + WIDTH_W'(1);
            bump_next  = {bump_reg[INDEX_W-2:0], 1'b0};
        end
        else if (restore)
        begin
            width_next = WIDTH_W'(INITIAL_WIDTH);
            bump_next  = INDEX_W'(INITIAL_BUMP);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg  <= 8'd0;
            fill_reg  <= 3'd0;
            width_reg <= WIDTH_W'(INITIAL_WIDTH);
            bump_reg  <= INDEX_W'(INITIAL_BUMP);
        end
        else if (fire)
        begin
            pend_reg  <= pend_next;
            fill_reg  <= fill_next;
            width_reg <= width_next;
            bump_reg  <= bump_next;
        end
    end

endmodule

`default_nettype wire

### sv/lzwp_out_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module lzwp_out_queue (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  wire lzwp_pkg::pack_res_t  res,
    output logic                      room,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output lzwp_pkg::out_item_t       out_item
);
    import lzwp_pkg::*;

    out_item_t  entries [4];
    logic [1:0] wr_ptr_reg, wr_ptr_next;
    logic [1:0] rd_ptr_reg, rd_ptr_next;
    logic [2:0] count_reg, count_next;
    logic [1:0] n_push;
    logic       pop;

    always_comb
    begin
        pop         = out_valid && out_ready;
        n_push      = push ? res.count : 2'd0;
        wr_ptr_next = wr_ptr_reg + n_push;
        rd_ptr_next = rd_ptr_reg + {1'b0, pop};
        count_next  = count_reg + {1'b0, n_push} - {2'b0, pop};
    end

    // Room for a worst-case item of three bytes
    assign room      = (count_reg <= 3'd1);
    assign out_valid = (count_reg != 3'd0);
    assign out_item  = entries[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            if (2'(k) < n_push)
            begin
                entries[wr_ptr_reg + 2'(k)] <= '{out_byte: res.bytes[k],
                                                 last: (2'(k) == n_push - 2'd1)};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 2'd0;
            rd_ptr_reg <= 2'd0;
            count_reg  <= 3'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

### sv/lzwp_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module lzwp_checker (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_ready,
    input  wire logic                            out_valid,
    input  wire logic                            out_ready,
    input  wire lzwp_pkg::out_item_t             out_item
);
    import lzwp_pkg::*;

    // A stalled byte stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output item dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_item))
        else $error("output item changed while stalled");

    // All bytes of an item are queued together, so a non-final byte has a successor
    a_item_whole: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !out_item.last |=> out_valid)
        else $error("item bytes split across a gap");

    // Input back-pressure only comes from a queue holding bytes
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input stalled with empty output queue");

endmodule

bind lzw_code_bit_packer lzwp_checker u_checker (.*);

`default_nettype wire

### bench/tb.sv
`timescale 1ns / 1ps

module tb;
    import lzwp_pkg::*;

    typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;

    typedef struct {
        row_kind_t                kind;
        in_item_t                 item;
        logic [CFG_IDX_W-1:0]     reg_idx;
        logic [CFG_DATA_W-1:0]    reg_val;
        bit                       typed;
        pack_res_t                want;
    } dir_row_t;

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_ready;
    in_item_t                 in_item;
    logic                     out_valid;
    logic                     out_ready;
    out_item_t                out_item;
    logic                     cfg_we;
    logic [CFG_IDX_W-1:0]     cfg_index;
    logic [CFG_DATA_W-1:0]    cfg_data;

    // Predictor state and register copies
    logic [23:0]              acc_bits;
    logic [4:0]               acc_fill;
    logic [4:0]               cur_width;
    logic [INDEX_W-1:0]       bump_at;
    logic [INDEX_W-1:0]       lim_reg;
    logic                     rw_reg;
    logic [CODE_W-1:0]        eof_reg;

    out_item_t                pending_bytes[$];
    dir_row_t                 dir_rows[$];
    logic [INDEX_W-1:0]       run_idx;

    int send_idle_pct;
    int recv_stall_pct;
    int err_count;
    int items_sent;
    int finishes_sent;
    int bytes_seen;
    int reg_writes;
    int widest;

    lzw_code_bit_packer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #200000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH at %0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
        err_count++;
    endtask

    // Bytes one item completes, low byte first; advances the predictor state
    function automatic pack_res_t predict_bytes(input in_item_t it);
        pack_res_t    res;
        logic [15:0]  code;
        logic [15:0]  mask;
        longint       limit;
        res   = '0;
        code  = (it.opcode == OP_FINISH) ? eof_reg : it.code_value;
        mask  = (cur_width >= 16) ? 16'hFFFF : 16'((32'd1 << cur_width) - 1);
        limit = longint'(lim_reg) - 1;
        acc_bits = acc_bits | ({8'h00, code & mask} << acc_fill[2:0]);
        acc_fill = acc_fill + cur_width;
        while (acc_fill >= 8)
        begin
            res.bytes[res.count] = acc_bits[7:0];
            res.count            = res.count + 2'd1;
            acc_bits             = acc_bits >> 8;
            acc_fill             = acc_fill - 5'd8;
        end
        if (longint'(it.dict_index) < limit)
        begin
            if (it.dict_index == bump_at && cur_width < MAX_WIDTH_DEF)
            begin
                bump_at   = bump_at << 1;
                cur_width = cur_width + 5'd1;
            end
        end
        else if (longint'(it.dict_index) != limit)
        begin
            if (rw_reg)
            begin
                cur_width = INITIAL_WIDTH_DEF;
                bump_at   = INITIAL_BUMP_DEF;
            end
        end
        if (it.opcode == OP_FINISH)
        begin
            // flush the partial byte, unused high bits already zero
            if (acc_fill > 0)
            begin
                res.bytes[res.count] = acc_bits[7:0];
                res.count            = res.count + 2'd1;
            end
            acc_bits = '0;
            acc_fill = '0;
        end
        if (cur_width > widest)
            widest = cur_width;
        return res;
    endfunction

    function automatic void add_item(input logic op, input logic [15:0] code,
                                     input logic [16:0] idx, input bit typed = 1'b0,
                                     input pack_res_t want = '0);
        dir_row_t row;
        row.kind    = ROW_ITEM;
        row.item    = '{opcode: op, code_value: code, dict_index: idx};
        row.reg_idx = '0;
        row.reg_val = '0;
        row.typed   = typed;
        row.want    = want;
        dir_rows.push_back(row);
    endfunction

    function automatic void add_reg(input logic [CFG_IDX_W-1:0] ridx,
                                    input logic [CFG_DATA_W-1:0] val);
        dir_row_t row;
        row.kind    = ROW_REG;
        row.item    = '0;
        row.reg_idx = ridx;
        row.reg_val = val;
        row.typed   = 1'b0;
        row.want    = '0;
        dir_rows.push_back(row);
    endfunction

    function automatic in_item_t next_random_item();
        in_item_t it;
        it.opcode = ($urandom_range(0, 99) < 8) ? OP_FINISH : OP_PACK;
        if ($urandom_range(0, 99) < 85)
            run_idx = run_idx + 17'd1;
        else
        begin
            // start a new run, mostly just below a width step or the limit
            case ($urandom_range(0, 4))
                0, 1:    run_idx = bump_at - 17'($urandom_range(0, 3));
                2:       run_idx = lim_reg - 17'd1 - 17'($urandom_range(0, 2));
                3:       run_idx = 17'($urandom);
                default: run_idx = '0;
            endcase
        end
        it.dict_index = run_idx;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5:
                it.code_value = 16'($urandom_range(0, (32'd1 << cur_width) - 1));
            6, 7, 8:
                it.code_value = 16'($urandom);
            default:
                it.code_value = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        endcase
        return it;
    endfunction

    task automatic send_item(input in_item_t it, input bit typed, input pack_res_t want);
        pack_res_t res;
        out_item_t b;
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do
            @(posedge clk);
        while (!in_ready);
        res = predict_bytes(it);
        if (typed)
            res = want;
        for (int i = 0; i < res.count; i++)
        begin
            b.out_byte = res.bytes[i];
            b.last     = (i == res.count - 1);
            pending_bytes.push_back(b);
        end
        items_sent++;
        if (it.opcode == OP_FINISH)
            finishes_sent++;
    endtask

    // Drop valid, drain every expected byte, then allow for items that emit nothing
    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_bytes.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] ridx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= ridx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
        case (ridx)
            CFG_MAX_INDEX:   lim_reg = val;
            CFG_RESET_WIDTH: rw_reg  = val[0];
            CFG_EOF_CODE:    eof_reg = val[CODE_W-1:0];
            default:         ;
        endcase
        reg_writes++;
    endtask

    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            out_ready <= ($urandom_range(0, 99) < recv_stall_pct) ? 1'b0 : 1'b1;
        end
    end

    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            bytes_seen++;
            if (pending_bytes.size() == 0)
            begin
                $display("MISMATCH at %0t: byte 0x%0h with nothing expected",
                         $realtime, out_item.out_byte);
                err_count++;
            end
            else
            begin
                want = pending_bytes.pop_front();
                if (out_item.out_byte !== want.out_byte)
                    report_mismatch("out_byte", out_item.out_byte, want.out_byte);
                if (out_item.last !== want.last)
                    report_mismatch("last", out_item.last, want.last);
            end
        end
    end

    initial
    begin
        int send_pct[4];
        int recv_pct[4];
        send_pct = '{0, 50, 0, 15};
        recv_pct = '{0, 0, 50, 15};
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        in_item        = '0;
        cfg_we         = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        err_count      = 0;
        items_sent     = 0;
        finishes_sent  = 0;
        bytes_seen     = 0;
        reg_writes     = 0;
        acc_bits       = '0;
        acc_fill       = '0;
        cur_width      = INITIAL_WIDTH_DEF;
        bump_at        = INITIAL_BUMP_DEF;
        widest         = INITIAL_WIDTH_DEF;
        lim_reg        = MAX_INDEX_RST;
        rw_reg         = RESET_WIDTH_RST;
        eof_reg        = EOF_CODE_RST;
        run_idx        = 17'd258;

        // Expected bytes are {count, byte2, byte1, byte0}, low byte first
        add_item(OP_PACK,   16'h01FF, 17'd258, 1'b1, {2'd1, 24'h0000FF});
        add_item(OP_FINISH, 16'h0000, 17'd259, 1'b1, {2'd2, 24'h000201});
        // wider code than the width: masked to nine bits
        add_item(OP_PACK,   16'hFFFF, 17'd0,   1'b1, {2'd1, 24'h0000FF});
        add_item(OP_PACK,   16'h0000, 17'd512, 1'b1, {2'd1, 24'h000001});
        add_item(OP_PACK,   16'h03FF, 17'd513);
        add_item(OP_FINISH, 16'h0000, 17'd1000);
        add_item(OP_FINISH, 16'hFFFF, 17'd1001);
        // index one below the limit leaves the width, the limit and above restore it
        add_item(OP_PACK,   16'h1234, 17'd4095);
        add_item(OP_PACK,   16'hABCD, 17'd4096);
        add_item(OP_PACK,   16'h5555, 17'h1FFFF);
        // grow the width to its ceiling with width restore off
        add_reg(CFG_MAX_INDEX, 17'h1FFFF);
        add_reg(CFG_RESET_WIDTH, 17'd0);
        add_item(OP_PACK,   16'hFFFF, 17'd512);
        add_item(OP_PACK,   16'h0000, 17'd1024);
        add_item(OP_PACK,   16'hA5A5, 17'd2048);
        add_item(OP_PACK,   16'h5A5A, 17'd4096);
        add_item(OP_PACK,   16'hFFFF, 17'd8192);
        add_item(OP_PACK,   16'h8001, 17'd16384);
        add_item(OP_PACK,   16'h7FFE, 17'd32768);
        add_item(OP_PACK,   16'hFFFF, 17'd65536);
        add_item(OP_PACK,   16'hC3C3, 17'h1FFFF);
        // a zero limit makes every index count as past it
        add_reg(CFG_MAX_INDEX, 17'd0);
        add_reg(CFG_RESET_WIDTH, 17'd1);
        add_item(OP_PACK,   16'hFFFF, 17'd0);
        add_reg(CFG_EOF_CODE, 17'h0FFFF);
        add_item(OP_FINISH, 16'h0000, 17'd0);

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].kind == ROW_REG)
            begin
                wait_idle();
                write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_val);
            end
            else
                send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);
        end

        for (int ph = 0; ph < 4; ph++)
        begin
            wait_idle();
            send_idle_pct  = send_pct[ph];
            recv_stall_pct = recv_pct[ph];
            case (ph)
                0:
                begin
                    write_reg(CFG_MAX_INDEX, 17'd4096);
                    write_reg(CFG_RESET_WIDTH, 17'd1);
                    write_reg(CFG_EOF_CODE, 17'd256);
                end
                1:
                begin
                    write_reg(CFG_MAX_INDEX, 17'd2);
                    write_reg(CFG_RESET_WIDTH, 17'd0);
                    write_reg(CFG_EOF_CODE, 17'd0);
                end
                2:
                begin
                    write_reg(CFG_MAX_INDEX, 17'd65536);
                    write_reg(CFG_RESET_WIDTH, 17'd1);
                    write_reg(CFG_EOF_CODE, 17'h0FFFF);
                end
                default:
                begin
                    write_reg(CFG_MAX_INDEX, 17'($urandom_range(0, 4000)));
                    write_reg(CFG_RESET_WIDTH, 17'($urandom_range(0, 1)));
                    write_reg(CFG_EOF_CODE, 17'($urandom_range(0, 65535)));
                end
            endcase
            for (int n = 0; n < 50; n++)
                send_item(next_random_item(), 1'b0, '0);
        end

        wait_idle();
        $display("Sent %0d items (%0d finishes), checked %0d bytes, %0d register writes",
                 items_sent, finishes_sent, bytes_seen, reg_writes);
        $display("Code width reached %0d bits across four handshake pressure modes", widest);
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
